>>> hdl/dvdd_pkg.sv
// Shared types, constants and calendar helpers for the date check and day difference block.
package dvdd_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned COUNT_W  = 22;

  // Day of year fits 1..366.
  localparam int unsigned DOY_W    = 9;
  // Shifted year y + 399 stays below 2^15 for any 14-bit year.
  localparam int unsigned SYEAR_W  = YEAR_W + 1;
  localparam int unsigned QUART_W  = SYEAR_W - 2;
  localparam int unsigned CENT_W   = 8;
  // Day number of the latest representable date stays below 2^23.
  localparam int unsigned DNUM_W   = 23;
  // Width used to compare a year against the upper year bound.
  localparam int unsigned YCMP_W   = 17;

  localparam logic [SYEAR_W-1:0] YEAR_OFFSET = SYEAR_W'(399);
  localparam logic [DNUM_W-1:0]  DAYS_YEAR   = DNUM_W'(365);

  // Division by 25 as multiply by ceil(2^17/25) and shift right by 17.
  localparam int unsigned        RECIP_W     = 25;
  localparam int unsigned        RECIP_SHIFT = 17;
  localparam logic [RECIP_W-1:0] RECIP_25    = RECIP_W'(5243);

  localparam logic [HOUR_W-1:0]   HOUR_LAST   = HOUR_W'(23);
  localparam logic [MINUTE_W-1:0] MINUTE_LAST = MINUTE_W'(59);
  localparam logic [SECOND_W-1:0] SECOND_LAST = SECOND_W'(59);
  localparam logic [COUNT_W-1:0]  COUNT_MAX   = {COUNT_W{1'b1}};

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [MONTH_W-1:0] {
    MON_JAN = 4'd1,  MON_FEB = 4'd2,  MON_MAR = 4'd3,  MON_APR = 4'd4,
    MON_MAY = 4'd5,  MON_JUN = 4'd6,  MON_JUL = 4'd7,  MON_AUG = 4'd8,
    MON_SEP = 4'd9,  MON_OCT = 4'd10, MON_NOV = 4'd11, MON_DEC = 4'd12
  } month_e;

  typedef struct packed {
    logic [YEAR_W-1:0]   year_a;
    logic [MONTH_W-1:0]  month_a;
    logic [DAY_W-1:0]    day_a;
    logic [HOUR_W-1:0]   hour_a;
    logic [MINUTE_W-1:0] minute_a;
    logic [SECOND_W-1:0] second_a;
    logic [YEAR_W-1:0]   year_b;
    logic [MONTH_W-1:0]  month_b;
    logic [DAY_W-1:0]    day_b;
  } dvdd_in_t;

  typedef struct packed {
    logic               date_ok;
    logic               time_ok;
    logic               second_date_ok;
    logic [COUNT_W-1:0] day_count;
  } dvdd_out_t;

  typedef struct packed {
    logic ok_a;
    logic ok_t;
    logic ok_b;
    logic run;
  } dvdd_flags_t;

  // Classified job handed from the front end to the arithmetic back end.
  typedef struct packed {
    dvdd_flags_t        flags;
    logic [YEAR_W-1:0]  year_a;
    logic [DOY_W-1:0]   doy_a;
    logic [YEAR_W-1:0]  year_b;
    logic [DOY_W-1:0]   doy_b;
  } dvdd_job_t;

  function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      MON_FEB:                             len = leap ? DAY_W'(29) : DAY_W'(28);
      MON_APR, MON_JUN, MON_SEP, MON_NOV:  len = DAY_W'(30);
      MON_JAN, MON_MAR, MON_MAY, MON_JUL,
      MON_AUG, MON_OCT, MON_DEC:           len = DAY_W'(31);
      default:                             len = '0;
    endcase
    return len;
  endfunction

  // Days in the months before month m.
  function automatic logic [DOY_W-1:0] month_start(logic [MONTH_W-1:0] m, logic leap);
    logic [DOY_W-1:0] base;
    unique case (m)
      MON_JAN: base = DOY_W'(0);
      MON_FEB: base = DOY_W'(31);
      MON_MAR: base = DOY_W'(59);
      MON_APR: base = DOY_W'(90);
      MON_MAY: base = DOY_W'(120);
      MON_JUN: base = DOY_W'(151);
      MON_JUL: base = DOY_W'(181);
      MON_AUG: base = DOY_W'(212);
      MON_SEP: base = DOY_W'(243);
      MON_OCT: base = DOY_W'(273);
      MON_NOV: base = DOY_W'(304);
      MON_DEC: base = DOY_W'(334);
      default: base = '0;
    endcase
    if (leap && (m > MON_FEB)) begin
      base = base + DOY_W'(1);
    end
    return base;
  endfunction

endpackage

>>> hdl/date_validate_and_day_difference.sv
// Top level: Gregorian date check and absolute day difference between two dates.
// An accepted input is held in the job queue, then in the s1, s2 and output registers.
// Throughput: one transaction per cycle while the output is not stalled; the back end's
// three register stages advance independently and a two-entry job queue separates them
// from the classifying front end. Reset clears the queue pointers and the stage valid
// bits; no clearing pass is needed, and the input is ready once reset is released.
module date_validate_and_day_difference #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dvdd_pkg::dvdd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dvdd_pkg::dvdd_out_t out_data_o
);
  import dvdd_pkg::*;

  dvdd_job_t front_job;
  logic      front_valid;
  logic      front_ready;
  dvdd_job_t back_job;
  logic      back_valid;
  logic      back_ready;

  dvdd_front #(
    .MAX_YEAR(MAX_YEAR)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .job_valid_o(front_valid),
    .job_ready_i(front_ready),
    .job_o      (front_job)
  );

  dvdd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .push_data_i (front_job),
    .pop_valid_o (back_valid),
    .pop_ready_i (back_ready),
    .pop_data_o  (back_job)
  );

  dvdd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(back_valid),
    .job_ready_o(back_ready),
    .job_i      (back_job),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> hdl/dvdd_front.sv
// Front end: checks both dates and the time of day and forms the day of year.
module dvdd_front #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dvdd_pkg::dvdd_in_t in_data_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output dvdd_pkg::dvdd_job_t job_o
);
  import dvdd_pkg::*;

  typedef struct packed {
    logic             ok;
    logic             in_range;
    logic [DOY_W-1:0] doy;
  } date_info_t;

  function automatic logic is_leap(logic [YEAR_W-1:0] y);
    logic [YEAR_W-3:0]  q4;
    logic [RECIP_W-1:0] prod;
    logic [CENT_W-1:0]  q100;
    logic [YEAR_W-3:0]  rem;
    logic               div4;
    logic               div100;
    logic               div400;
    q4     = y[YEAR_W-1:2];
    prod   = RECIP_W'(q4) * RECIP_25;
    q100   = prod[RECIP_W-1:RECIP_SHIFT];
    rem    = q4 - (YEAR_W-2)'(q100) * (YEAR_W-2)'(25);
    div4   = (y[1:0] == 2'b00);
    div100 = div4 && (rem == '0);
    div400 = div100 && (y[3:2] == 2'b00);
    return (div4 && !div100) || div400;
  endfunction

  function automatic date_info_t check_date(logic [YEAR_W-1:0] y,
                                            logic [MONTH_W-1:0] m,
                                            logic [DAY_W-1:0] d);
    date_info_t info;
    logic       leap;
    leap          = is_leap(y);
    info.ok       = (m >= MON_JAN) && (m <= MON_DEC) && (d != '0) &&
                    (d <= month_len(m, leap));
    info.in_range = (y != '0) && (YCMP_W'(y) <= YCMP_W'(MAX_YEAR));
    info.doy      = month_start(m, leap) + DOY_W'(d);
    return info;
  endfunction

  date_info_t info_a;
  date_info_t info_b;
  logic       time_ok;

  assign info_a  = check_date(in_data_i.year_a, in_data_i.month_a, in_data_i.day_a);
  assign info_b  = check_date(in_data_i.year_b, in_data_i.month_b, in_data_i.day_b);
  assign time_ok = (in_data_i.hour_a <= HOUR_LAST) &&
                   (in_data_i.minute_a <= MINUTE_LAST) &&
                   (in_data_i.second_a <= SECOND_LAST);

  always_comb begin
    job_o.flags.ok_a = info_a.ok;
    job_o.flags.ok_t = time_ok;
    job_o.flags.ok_b = info_b.ok;
    job_o.flags.run  = info_a.ok && info_b.ok && info_a.in_range && info_b.in_range;
    job_o.year_a     = in_data_i.year_a;
    job_o.doy_a      = info_a.doy;
    job_o.year_b     = in_data_i.year_b;
    job_o.doy_b      = info_b.doy;
  end

  assign job_valid_o = in_valid_i;
  assign in_ready_o  = job_ready_i;

endmodule

>>> hdl/dvdd_queue.sv
// Short queue of classified jobs between the front end and the back end.
module dvdd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  dvdd_pkg::dvdd_job_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output dvdd_pkg::dvdd_job_t pop_data_o
);
  import dvdd_pkg::*;

  dvdd_job_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/dvdd_back.sv
// Back end: day numbers of both dates, their absolute difference and the output register.
module dvdd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  dvdd_pkg::dvdd_job_t job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dvdd_pkg::dvdd_out_t out_data_o
);
  import dvdd_pkg::*;

  typedef struct packed {
    logic [DNUM_W-1:0]  base;
    logic [QUART_W-1:0] q4;
    logic [CENT_W-1:0]  q100;
    logic [DOY_W-1:0]   doy;
  } part_t;

  typedef struct packed {
    dvdd_flags_t flags;
    part_t       a;
    part_t       b;
  } s1_t;

  typedef struct packed {
    dvdd_flags_t       flags;
    logic [DNUM_W-1:0] na;
    logic [DNUM_W-1:0] nb;
  } s2_t;

  // First step: 365 times the shifted year and the century count, both from multipliers.
  function automatic part_t year_terms(logic [YEAR_W-1:0] y, logic [DOY_W-1:0] doy);
    part_t              p;
    logic [SYEAR_W-1:0] yy;
    logic [RECIP_W-1:0] prod;
    yy     = SYEAR_W'(y) + YEAR_OFFSET;
    p.base = DNUM_W'(yy) * DAYS_YEAR;
    p.q4   = yy[SYEAR_W-1:2];
    prod   = RECIP_W'(p.q4) * RECIP_25;
    p.q100 = prod[RECIP_W-1:RECIP_SHIFT];
    p.doy  = doy;
    return p;
  endfunction

  function automatic logic [DNUM_W-1:0] day_number(part_t p);
    return p.base + DNUM_W'(p.q4) - DNUM_W'(p.q100) + DNUM_W'(p.q100[CENT_W-1:2]) +
           DNUM_W'(p.doy);
  endfunction

  s1_t               s1_q;
  s2_t               s2_q;
  dvdd_out_t         out_q, out_d;
  logic              v1_q, v2_q, v3_q;
  logic              adv1, adv2, adv3;
  logic [DNUM_W-1:0] diff;

  assign adv3 = !v3_q || out_ready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign job_ready_o = adv1;
  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

  always_comb begin
    diff = (s2_q.na > s2_q.nb) ? s2_q.na - s2_q.nb : s2_q.nb - s2_q.na;
    out_d.date_ok        = s2_q.flags.ok_a;
    out_d.time_ok        = s2_q.flags.ok_t;
    out_d.second_date_ok = s2_q.flags.ok_b;
    if (!s2_q.flags.run) begin
      out_d.day_count = '0;
    end else if (diff > DNUM_W'(COUNT_MAX)) begin
      out_d.day_count = COUNT_MAX;
    end else begin
      out_d.day_count = diff[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= job_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_q.flags <= job_i.flags;
      s1_q.a     <= year_terms(job_i.year_a, job_i.doy_a);
      s1_q.b     <= year_terms(job_i.year_b, job_i.doy_b);
    end
    if (adv2) begin
      s2_q.flags <= s1_q.flags;
      s2_q.na    <= day_number(s1_q.a);
      s2_q.nb    <= day_number(s1_q.b);
    end
    if (adv3) begin
      out_q <= out_d;
    end
  end

endmodule

>>> hdl/dvdd_checker.sv
// Port-level checks for the date check and day difference block, bound to its top level.
module dvdd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input dvdd_pkg::dvdd_out_t out_data_o
);
  import dvdd_pkg::*;

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output result changed while stalled");

  // An invalid date never produces a nonzero day count.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !(out_data_o.date_ok && out_data_o.second_date_ok) |->
      out_data_o.day_count == '0)
    else $error("nonzero day count for an invalid date");

  // No result is shown while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // Leaving reset, the queue is empty and ready while nothing is pending.
  a_reset_ready: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_ready_o && !out_valid_o)
    else $error("block not empty and ready after reset");

endmodule

bind date_validate_and_day_difference dvdd_checker u_checker (.*);

>>> test/date_validate_and_day_difference_test.sv
// Testbench for the date check and day difference block: directed table, then random date pairs.
`timescale 1ns / 1ps

module date_validate_and_day_difference_test;
  import dvdd_pkg::*;

  localparam int unsigned CHECK_MAX_YEAR = 9999;
  localparam int unsigned RANDOM_ITEMS   = 400;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam bit          TYPED          = 1'b1;
  localparam bit          FROM_MODEL     = 1'b0;

  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int YEAR_EDGES [10] = '{1, 2, 9998, 9999, 1600, 1700, 1900, 2000, 2100, 2400};

  typedef struct {
    dvdd_in_t  stim;
    bit        typed;
    dvdd_out_t want;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni;
  logic      in_valid    = 1'b0;
  logic      in_ready_o;
  dvdd_in_t  in_data     = '0;
  logic      out_valid_o;
  logic      out_ready   = 1'b0;
  dvdd_out_t out_data_o;

  dvdd_out_t   pending_results [$];
  dir_row_t    dir_rows [$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned stall_cycles = 0;
  bit          steady       = 1'b0;
  bit          hold_req     = 1'b0;

  date_validate_and_day_difference #(
    .MAX_YEAR(CHECK_MAX_YEAR)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Calendar predictor.
  function automatic bit is_leap(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned days_of_month(int unsigned y, int unsigned m);
    if (m == MON_FEB && is_leap(y)) begin
      return 29;
    end
    return MONTH_DAYS[(m - 1) % 12];
  endfunction

  function automatic bit date_good(int unsigned y, int unsigned m, int unsigned d);
    if (m < MON_JAN || m > MON_DEC) begin
      return 1'b0;
    end
    return d >= 1 && d <= days_of_month(y, m);
  endfunction

  // Serial day number; the constant offset cancels in a difference.
  function automatic longint day_serial(int unsigned y, int unsigned m, int unsigned d);
    longint yy;
    longint n;
    yy = longint'(y) + 399;
    n  = 365 * yy + yy / 4 - yy / 100 + yy / 400;
    for (int unsigned k = MON_JAN; k < m; k++) begin
      n += days_of_month(y, k);
    end
    return n + d;
  endfunction

  function automatic dvdd_out_t predict_dates(dvdd_in_t s);
    dvdd_out_t r;
    bit        years_in;
    longint    span;
    r.date_ok        = date_good(s.year_a, s.month_a, s.day_a);
    r.time_ok        = s.hour_a <= 23 && s.minute_a <= 59 && s.second_a <= 59;
    r.second_date_ok = date_good(s.year_b, s.month_b, s.day_b);
    years_in = s.year_a >= 1 && s.year_a <= CHECK_MAX_YEAR &&
               s.year_b >= 1 && s.year_b <= CHECK_MAX_YEAR;
    span = 0;
    if (r.date_ok && r.second_date_ok && years_in) begin
      span = day_serial(s.year_a, s.month_a, s.day_a) - day_serial(s.year_b, s.month_b, s.day_b);
      if (span < 0) begin
        span = -span;
      end
      if (span > longint'(COUNT_MAX)) begin
        span = longint'(COUNT_MAX);
      end
    end
    r.day_count = COUNT_W'(span);
    return r;
  endfunction

  function automatic dvdd_in_t mk(int ya, int ma, int da, int h, int mi, int s,
                                  int yb, int mb, int db);
    dvdd_in_t t;
    t.year_a   = YEAR_W'(ya);
    t.month_a  = MONTH_W'(ma);
    t.day_a    = DAY_W'(da);
    t.hour_a   = HOUR_W'(h);
    t.minute_a = MINUTE_W'(mi);
    t.second_a = SECOND_W'(s);
    t.year_b   = YEAR_W'(yb);
    t.month_b  = MONTH_W'(mb);
    t.day_b    = DAY_W'(db);
    return t;
  endfunction

  function automatic dvdd_out_t outcome(bit oa, bit ot, bit ob, int cnt);
    dvdd_out_t r;
    r.date_ok        = oa;
    r.time_ok        = ot;
    r.second_date_ok = ob;
    r.day_count      = COUNT_W'(cnt);
    return r;
  endfunction

  task automatic add_row(input dvdd_in_t stim, input bit typed, input dvdd_out_t want);
    dir_row_t row;
    row.stim  = stim;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  function automatic int unsigned pick_year();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      return $urandom_range(1, CHECK_MAX_YEAR);
    end else if (sel < 93) begin
      return YEAR_EDGES[$urandom_range(0, 9)];
    end else if (sel < 96) begin
      return 0;
    end
    return $urandom_range(CHECK_MAX_YEAR + 1, (1 << YEAR_W) - 1);
  endfunction

  function automatic int unsigned bad_month();
    int unsigned sel;
    sel = $urandom_range(0, 3);
    return (sel == 0) ? 0 : 12 + sel;
  endfunction

  // Mostly well-formed date pairs; the rest has one broken field or is raw noise.
  function automatic dvdd_in_t gen_item();
    dvdd_in_t    t;
    logic [63:0] raw;
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      raw = {$urandom(), $urandom()};
      t   = raw[$bits(dvdd_in_t)-1:0];
      return t;
    end
    t.year_a  = YEAR_W'(pick_year());
    t.month_a = MONTH_W'($urandom_range(MON_JAN, MON_DEC));
    t.day_a   = DAY_W'($urandom_range(1, days_of_month(t.year_a, t.month_a)));
    t.year_b  = ($urandom_range(0, 99) < 30) ? t.year_a : YEAR_W'(pick_year());
    t.month_b = MONTH_W'($urandom_range(MON_JAN, MON_DEC));
    t.day_b   = DAY_W'($urandom_range(1, days_of_month(t.year_b, t.month_b)));
    if ($urandom_range(0, 99) < 10) begin
      t.hour_a   = HOUR_W'($urandom());
      t.minute_a = MINUTE_W'($urandom());
      t.second_a = SECOND_W'($urandom());
    end else begin
      t.hour_a   = HOUR_W'($urandom_range(0, 23));
      t.minute_a = MINUTE_W'($urandom_range(0, 59));
      t.second_a = SECOND_W'($urandom_range(0, 59));
    end
    if (kind >= 72) begin
      case ($urandom_range(0, 6))
        0: t.day_a = '0;
        1: begin
          len = days_of_month(t.year_a, t.month_a);
          t.day_a = (len == 31) ? DAY_W'(0) : DAY_W'($urandom_range(len + 1, 31));
        end
        2: t.month_a = MONTH_W'(bad_month());
        3: t.day_b = '0;
        4: begin
          len = days_of_month(t.year_b, t.month_b);
          t.day_b = (len == 31) ? DAY_W'(0) : DAY_W'($urandom_range(len + 1, 31));
        end
        5: t.month_b = MONTH_W'(bad_month());
        default: t.hour_a = HOUR_W'($urandom_range(24, 31));
      endcase
    end
    return t;
  endfunction

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // Sender side: optional idle cycles, then hold the transaction until it is taken.
  task automatic send_dates(input dvdd_in_t stim, input dvdd_out_t want);
    bit taken;
    if (!steady) begin
      while ($urandom_range(0, 99) < 24) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_data  <= stim;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    pending_results.push_back(want);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Receiver side: random back-pressure, plus one long hold-off on request.
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 24);
        @(posedge clk_i);
      end
    end
  end

  // Signals are stable at the falling edge, so this sees what the next rising edge accepts.
  always @(negedge clk_i) begin
    dvdd_out_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result without a pending transaction", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.date_ok !== want.date_ok) begin
          note_mismatch("date_ok", out_data_o.date_ok, want.date_ok);
        end
        if (out_data_o.time_ok !== want.time_ok) begin
          note_mismatch("time_ok", out_data_o.time_ok, want.time_ok);
        end
        if (out_data_o.second_date_ok !== want.second_date_ok) begin
          note_mismatch("second_date_ok", out_data_o.second_date_ok, want.second_date_ok);
        end
        if (out_data_o.day_count !== want.day_count) begin
          note_mismatch("day_count", out_data_o.day_count, want.day_count);
        end
      end
      results_seen++;
    end
  end

  always @(negedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    dvdd_in_t stim;

    // Reset falls after time zero so that every register sees the edge.
    #1 rst_ni = 1'b0;

    add_row(mk(1, MON_JAN, 1, 0, 0, 0, 1, MON_JAN, 1), TYPED, outcome(1, 1, 1, 0));
    add_row(mk(1, MON_JAN, 1, 23, 59, 59, 9999, MON_DEC, 31), TYPED,
            outcome(1, 1, 1, 3652058));
    add_row(mk(9999, MON_DEC, 31, 0, 0, 0, 1, MON_JAN, 1), TYPED, outcome(1, 1, 1, 3652058));
    add_row(mk(2000, 0, 15, 12, 30, 30, 2000, MON_JUN, 15), TYPED, outcome(0, 1, 1, 0));
    add_row(mk(2000, 13, 15, 12, 30, 30, 2000, 15, 15), TYPED, outcome(0, 1, 0, 0));
    add_row(mk(2000, 15, 31, 1, 1, 1, 2000, 0, 0), TYPED, outcome(0, 1, 0, 0));
    // Day zero is rejected; this row tries it in May for both dates.
    add_row(mk(2000, MON_MAY, 0, 0, 0, 0, 2000, MON_MAY, 0), TYPED, outcome(0, 1, 0, 0));
    add_row(mk(2000, MON_FEB, 29, 0, 0, 0, 2000, MON_MAR, 1), FROM_MODEL, '0);
    add_row(mk(1900, MON_FEB, 29, 0, 0, 0, 1900, MON_MAR, 1), TYPED, outcome(0, 1, 1, 0));
    add_row(mk(2024, MON_FEB, 29, 0, 0, 0, 2023, MON_FEB, 29), TYPED, outcome(1, 1, 0, 0));
    add_row(mk(2100, MON_FEB, 28, 5, 6, 7, 2400, MON_FEB, 29), FROM_MODEL, '0);
    // Year zero is a leap year for the flags but is out of range for the count.
    add_row(mk(0, MON_FEB, 29, 0, 0, 0, 2000, MON_JAN, 1), TYPED, outcome(1, 1, 1, 0));
    add_row(mk(16383, MON_DEC, 31, 0, 0, 0, 1, MON_JAN, 1), TYPED, outcome(1, 1, 1, 0));
    add_row(mk(9999, MON_DEC, 31, 0, 0, 0, 10000, MON_JAN, 1), TYPED, outcome(1, 1, 1, 0));
    add_row(mk(2020, MON_APR, 30, 24, 0, 0, 2020, MON_APR, 30), TYPED, outcome(1, 0, 1, 0));
    add_row(mk(2020, MON_APR, 31, 31, 63, 63, 2020, MON_APR, 30), TYPED, outcome(0, 0, 1, 0));
    add_row(mk(2020, MON_JUN, 30, 0, 60, 0, 2020, MON_JUN, 30), TYPED, outcome(1, 0, 1, 0));
    add_row(mk(2020, MON_JUN, 30, 0, 0, 60, 2020, MON_JUN, 30), TYPED, outcome(1, 0, 1, 0));
    add_row(mk(1999, MON_DEC, 31, 23, 59, 59, 2000, MON_JAN, 1), TYPED, outcome(1, 1, 1, 1));
    add_row(mk(2023, MON_JAN, 31, 8, 8, 8, 2023, MON_DEC, 31), FROM_MODEL, '0);
    add_row(mk(2023, MON_FEB, 28, 0, 0, 0, 2023, MON_MAR, 1), TYPED, outcome(1, 1, 1, 1));
    add_row(mk(2020, MON_NOV, 30, 0, 0, 0, 2021, MON_SEP, 31), TYPED, outcome(1, 1, 0, 0));
    add_row(mk(1600, MON_DEC, 31, 0, 0, 0, 1700, MON_JAN, 1), FROM_MODEL, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_dates(dir_rows[i].stim,
                 dir_rows[i].typed ? dir_rows[i].want : predict_dates(dir_rows[i].stim));
    end
    wait_results_drained();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // The long receiver hold-off fills the pipeline and queue while items keep coming.
      if (n == 100) begin
        hold_req = 1'b1;
      end
      steady = (n >= 150 && n < 250);
      if (n == 300) begin
        wait_results_drained();
      end
      stim = gen_item();
      send_dates(stim, predict_dates(stim));
    end
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
